// File: hdl/assert_macros.svh
// Assertion macros shared by the date adder modules.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// post holds in the cycle where pre holds
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// post holds in the cycle after pre
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/cda_pkg.sv
// Package of the calendar date adder: widths, codes, item type and
// Gregorian calendar helper functions. Depends on nothing.
package cda_pkg;

	localparam int YEAR_SPAN  = 128;
	localparam int BASE_YEAR  = 2000;
	localparam int LIMIT_YEAR = BASE_YEAR + YEAR_SPAN;
	localparam int N_CENT     = (YEAR_SPAN - 1) / 100 + 1;

	localparam int OP_W   = 2;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 12;
	localparam int AMT_W  = 16;
	localparam int STAT_W = 2;

	localparam int T_W        = 19;
	localparam int IDX_W      = AMT_W + 1;
	localparam int QUO_W      = 13;
	localparam int NY_W       = AMT_W + 1;
	localparam int DIV3_MUL   = 43691;
	localparam int DIV3_SHIFT = 17;
	localparam int PROD_W     = IDX_W - 2 + 16;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_DAYS   = 2'd0;
	localparam logic [OP_W-1:0] OP_WEEKS  = 2'd1;
	localparam logic [OP_W-1:0] OP_MONTHS = 2'd2;
	localparam logic [OP_W-1:0] OP_YEARS  = 2'd3;

	localparam logic [1:0] KIND_BAD    = 2'd0;
	localparam logic [1:0] KIND_DAYS   = 2'd1;
	localparam logic [1:0] KIND_MONTHS = 2'd2;
	localparam logic [1:0] KIND_YEARS  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_DATE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SPAN     = 2'd2;

	localparam logic [MON_W-1:0] MON_JAN = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic [1:0]        kind;
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [T_W-1:0]    amt;
	} cda_item_t;

	// valid for years from BASE_YEAR below LIMIT_YEAR
	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		logic cent;
		cent = 1'b0;
		for (int k = 0; k < N_CENT; k++) begin
			if (y == YEAR_W'(BASE_YEAR + 100 * k))
				cent = 1'b1;
		end
		return (y[1:0] == 2'd0) && (!cent || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
		input logic [MON_W-1:0] m);
		logic [DAY_W-1:0] n;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			MON_FEB:                 n = leap ? 5'd29 : 5'd28;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [T_W-1:0] days_in_year(input logic leap);
		return leap ? T_W'(366) : T_W'(365);
	endfunction

endpackage

// File: hdl/cda_front.sv
// Front part of the date adder: validates the start date and classifies
// each item for the back part. Depends on cda_pkg.
module cda_front (
	input  logic                      push,
	input  logic                      q_full,
	input  logic [cda_pkg::OP_W-1:0]  op,
	input  logic [cda_pkg::DAY_W-1:0] from_day,
	input  logic [cda_pkg::MON_W-1:0] from_month,
	input  logic [cda_pkg::YEAR_W-1:0] from_year,
	input  logic [cda_pkg::AMT_W-1:0] amount,
	output logic                      q_wr,
	output cda_pkg::cda_item_t        q_item
);
	import cda_pkg::*;

	logic             date_ok;
	logic [DAY_W-1:0] mlen;
	logic [T_W-1:0]   amt_ext;

	assign mlen    = days_in_month(leap_year(from_year), from_month);
	assign date_ok = (from_month >= MON_JAN) && (from_month <= MON_DEC) &&
		(from_day != '0) && (from_year >= YEAR_W'(BASE_YEAR)) &&
		(from_year < YEAR_W'(LIMIT_YEAR)) && (from_day <= mlen);
	assign amt_ext = T_W'(amount);

	always_comb begin
		q_item.day   = from_day;
		q_item.month = from_month;
		q_item.year  = from_year;
		q_item.amt   = amt_ext;
		q_item.kind  = KIND_BAD;
		if (date_ok) begin
			case (op)
				OP_DAYS:   q_item.kind = KIND_DAYS;
				OP_WEEKS: begin
					q_item.kind = KIND_DAYS;
					q_item.amt  = (amt_ext << 3) - amt_ext;
				end
				OP_MONTHS: q_item.kind = KIND_MONTHS;
				default:   q_item.kind = KIND_YEARS;
			endcase
		end
	end

	assign q_wr = push && !q_full;

endmodule

// File: hdl/cda_queue.sv
// Short queue of classified items between front and back part.
// Depends on cda_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cda_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  cda_pkg::cda_item_t wr_item,
	output logic               full,
	input  logic               rd,
	output cda_pkg::cda_item_t rd_item,
	output logic               empty
);
	import cda_pkg::*;

	cda_item_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wptr_q;
	logic [Q_AW-1:0]  rptr_q;
	logic [Q_CW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == Q_CW'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= Q_CW'(Q_DEPTH), "queue overfilled")
	`ASSERT_NEXT(a_count_up, clk, arst_n, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "queue count lost a write")

endmodule

// File: hdl/cda_back.sv
// Back part of the date adder: walks month and year lengths or divides
// month counts, clamps the day and holds the result. Depends on cda_pkg
// and assert_macros.svh.
`include "assert_macros.svh"
module cda_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  cda_pkg::cda_item_t          q_item,
	output logic                        q_rd,
	input  logic                        pop,
	output logic                        empty,
	output logic [cda_pkg::DAY_W-1:0]   result_day,
	output logic [cda_pkg::MON_W-1:0]   result_month,
	output logic [cda_pkg::YEAR_W-1:0]  result_year,
	output logic [cda_pkg::STAT_W-1:0]  status
);
	import cda_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MSUM  = 3'd1;
	localparam logic [2:0] S_YWALK = 3'd2;
	localparam logic [2:0] S_MWALK = 3'd3;
	localparam logic [2:0] S_MDIV  = 3'd4;
	localparam logic [2:0] S_MREM  = 3'd5;
	localparam logic [2:0] S_CLAMP = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]         st_q;
	logic [2:0]         st_d;
	logic [T_W-1:0]     t_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MON_W-1:0]   mon_q;
	logic [MON_W-1:0]   smon_q;
	logic [DAY_W-1:0]   day_q;
	logic               leap_q;
	logic [IDX_W-1:0]   idx_q;
	logic [QUO_W-1:0]   quo_q;
	logic [DAY_W-1:0]   rd_q;
	logic [MON_W-1:0]   rm_q;
	logic [YEAR_W-1:0]  ry_q;
	logic [STAT_W-1:0]  rs_q;
	logic               out_valid_q;
	logic [DAY_W-1:0]   od_q;
	logic [MON_W-1:0]   om_q;
	logic [YEAR_W-1:0]  oy_q;
	logic [STAT_W-1:0]  os_q;

	logic [T_W-1:0]     dim_cur;
	logic [T_W-1:0]     diy_cur;
	logic [PROD_W-1:0]  prod;
	logic [IDX_W-1:0]   quo12;
	logic [MON_W-1:0]   rem;
	logic [NY_W-1:0]    ny_m;
	logic [NY_W-1:0]    ny_y;
	logic [DAY_W-1:0]   clen;
	logic               ylimit;
	logic               out_free;
	logic               start;

	assign dim_cur  = T_W'(days_in_month(leap_q, mon_q));
	assign diy_cur  = days_in_year(leap_q);
	assign prod     = PROD_W'(idx_q[IDX_W-1:2]) * PROD_W'(DIV3_MUL);
	assign quo12    = (IDX_W'(quo_q) << 3) + (IDX_W'(quo_q) << 2);
	assign rem      = MON_W'(idx_q - quo12);
	assign ny_m     = NY_W'(year_q) + NY_W'(quo_q);
	assign ny_y     = NY_W'(q_item.year) + NY_W'(q_item.amt[AMT_W-1:0]);
	assign clen     = days_in_month(leap_year(year_q), mon_q);
	assign ylimit   = (year_q >= YEAR_W'(LIMIT_YEAR));
	assign out_free = !out_valid_q || pop;
	assign start    = (st_q == S_IDLE) && !q_empty;
	assign q_rd     = start;

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (!q_empty) begin
					case (q_item.kind)
						KIND_DAYS:   st_d = S_MSUM;
						KIND_MONTHS: st_d = S_MDIV;
						KIND_YEARS:  st_d = (ny_y >= NY_W'(LIMIT_YEAR)) ? S_DONE : S_CLAMP;
						default:     st_d = S_DONE;
					endcase
				end
			end
			S_MSUM:  if (mon_q >= smon_q) st_d = S_YWALK;
			S_YWALK: begin
				if (ylimit)
					st_d = S_DONE;
				else if (t_q < diy_cur)
					st_d = S_MWALK;
			end
			S_MWALK: if (mon_q >= MON_DEC || t_q < dim_cur) st_d = S_DONE;
			S_MDIV:  st_d = S_MREM;
			S_MREM:  st_d = (ny_m >= NY_W'(LIMIT_YEAR)) ? S_DONE : S_CLAMP;
			S_CLAMP: st_d = S_DONE;
			default: if (out_free) st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (!q_empty) begin
					day_q <= q_item.day;
					case (q_item.kind)
						KIND_DAYS: begin
							year_q <= q_item.year;
							t_q    <= T_W'(q_item.day) - 1'b1 + q_item.amt;
							mon_q  <= MON_JAN;
							smon_q <= q_item.month;
							leap_q <= leap_year(q_item.year);
						end
						KIND_MONTHS: begin
							year_q <= q_item.year;
							idx_q <= IDX_W'(q_item.month) - 1'b1 + IDX_W'(q_item.amt[AMT_W-1:0]);
						end
						KIND_YEARS: begin
							year_q <= YEAR_W'(ny_y);
							mon_q  <= q_item.month;
							rd_q   <= '0;
							rm_q   <= '0;
							ry_q   <= '0;
							rs_q   <= STAT_SPAN;
						end
						default: begin
							rd_q <= '0;
							rm_q <= '0;
							ry_q <= '0;
							rs_q <= STAT_BAD_DATE;
						end
					endcase
				end
			end
			S_MSUM: begin
				if (mon_q < smon_q) begin
					t_q   <= t_q + dim_cur;
					mon_q <= mon_q + 1'b1;
				end
			end
			S_YWALK: begin
				if (ylimit) begin
					rd_q <= '0;
					rm_q <= '0;
					ry_q <= '0;
					rs_q <= STAT_SPAN;
				end else if (t_q >= diy_cur) begin
					t_q    <= t_q - diy_cur;
					year_q <= year_q + 1'b1;
					leap_q <= leap_year(year_q + 1'b1);
				end else begin
					mon_q <= MON_JAN;
				end
			end
			S_MWALK: begin
				if (mon_q < MON_DEC && t_q >= dim_cur) begin
					t_q   <= t_q - dim_cur;
					mon_q <= mon_q + 1'b1;
				end else begin
					rd_q <= DAY_W'(t_q + 1'b1);
					rm_q <= mon_q;
					ry_q <= year_q;
					rs_q <= STAT_OK;
				end
			end
			S_MDIV: quo_q <= QUO_W'(prod >> DIV3_SHIFT);
			S_MREM: begin
				year_q <= YEAR_W'(ny_m);
				mon_q  <= rem + 1'b1;
				rd_q   <= '0;
				rm_q   <= '0;
				ry_q   <= '0;
				rs_q   <= STAT_SPAN;
			end
			S_CLAMP: begin
				rd_q <= (day_q > clen) ? clen : day_q;
				rm_q <= mon_q;
				ry_q <= year_q;
				rs_q <= STAT_OK;
			end
			default: begin
				if (out_free) begin
					od_q <= rd_q;
					om_q <= rm_q;
					oy_q <= ry_q;
					os_q <= rs_q;
				end
			end
		endcase
	end

	assign empty        = !out_valid_q;
	assign result_day   = od_q;
	assign result_month = om_q;
	assign result_year  = oy_q;
	assign status       = os_q;

	`ASSERT_IMPLY(a_err_zero, clk, arst_n, out_valid_q && os_q != STAT_OK, od_q == '0 && om_q == '0 && oy_q == '0, "error result carries a date")
	`ASSERT_IMPLY(a_ok_date, clk, arst_n, out_valid_q && os_q == STAT_OK, od_q != '0 && om_q >= MON_JAN && om_q <= MON_DEC, "result date out of range")

endmodule

// File: hdl/calendar_date_add_core.sv
// Month units divide, take the remainder and clamp the day; year units clamp it;
// day and week units sum the months before the start, then walk years and months;
// invalid dates, and results found past the year span, skip the remaining steps.
// cda_back starts the next item only after its last result has moved to the output.
// Reset: arst_n clears queue pointers, back state and the result valid flag.
// Top level of the date adder; depends on cda_pkg, cda_front, cda_queue, cda_back.
module calendar_date_add_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [cda_pkg::OP_W-1:0]    op,
	input  logic [cda_pkg::DAY_W-1:0]   from_day,
	input  logic [cda_pkg::MON_W-1:0]   from_month,
	input  logic [cda_pkg::YEAR_W-1:0]  from_year,
	input  logic [cda_pkg::AMT_W-1:0]   amount,
	output logic                        empty,
	input  logic                        pop,
	output logic [cda_pkg::DAY_W-1:0]   result_day,
	output logic [cda_pkg::MON_W-1:0]   result_month,
	output logic [cda_pkg::YEAR_W-1:0]  result_year,
	output logic [cda_pkg::STAT_W-1:0]  status
);
	import cda_pkg::*;

	logic      q_wr;
	logic      q_rd;
	logic      q_empty;
	cda_item_t wr_item;
	cda_item_t rd_item;

	cda_front u_front (
		.push       (push),
		.q_full     (full),
		.op         (op),
		.from_day   (from_day),
		.from_month (from_month),
		.from_year  (from_year),
		.amount     (amount),
		.q_wr       (q_wr),
		.q_item     (wr_item)
	);

	cda_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (wr_item),
		.full    (full),
		.rd      (q_rd),
		.rd_item (rd_item),
		.empty   (q_empty)
	);

	cda_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_item       (rd_item),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.status       (status)
	);

endmodule

// File: sim/calendar_date_add_core_test.sv
// Self-checking testbench of calendar_date_add_core: table requests, most with typed
// results, then random ones checked by a predictor; depends on cda_pkg and the RTL.
module calendar_date_add_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cda_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [AMT_W-1:0]  amount;
	} date_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [STAT_W-1:0] status;
	} date_result_t;

	typedef struct {
		date_req_t    req;
		bit           typed;
		date_result_t want;
	} date_case_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [OP_W-1:0]    op;
	logic [DAY_W-1:0]   from_day;
	logic [MON_W-1:0]   from_month;
	logic [YEAR_W-1:0]  from_year;
	logic [AMT_W-1:0]   amount;
	logic               empty;
	logic               pop;
	logic [DAY_W-1:0]   result_day;
	logic [MON_W-1:0]   result_month;
	logic [YEAR_W-1:0]  result_year;
	logic [STAT_W-1:0]  status;

	date_result_t pending_dates[$];
	date_case_t   directed_cases[$];
	int           fail_count = 0;
	int           send_idle_pct = 26;
	int           recv_idle_pct = 68;

	calendar_date_add_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.from_day     (from_day),
		.from_month   (from_month),
		.from_year    (from_year),
		.amount       (amount),
		.empty        (empty),
		.pop          (pop),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("** calendar_date_add_core: FAILED **");
		$finish;
	end

	function automatic bit is_leap(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_days(input int y, input int m);
		int n;
		case (m)
			4, 6, 9, 11: n = 30;
			2:           n = is_leap(y) ? 29 : 28;
			default:     n = 31;
		endcase
		return n;
	endfunction

	function automatic int year_days(input int y);
		return is_leap(y) ? 366 : 365;
	endfunction

	function automatic date_result_t predict_date_sum(input date_req_t r);
		date_result_t res;
		int d, m, y, amt, t, idx, k, ny, nm, nd;
		d = r.day;
		m = r.month;
		y = r.year;
		amt = r.amount;
		res = '0;
		if (m < 1 || m > 12 || d < 1 || y < BASE_YEAR || y >= LIMIT_YEAR ||
			d > month_days(y, m)) begin
			res.status = STAT_BAD_DATE;
			return res;
		end
		if (r.op == OP_MONTHS || r.op == OP_YEARS) begin
			idx = (m - 1) + ((r.op == OP_YEARS) ? amt * 12 : amt);
			ny = y + idx / 12;
			nm = idx % 12 + 1;
			if (ny >= LIMIT_YEAR) begin
				res.status = STAT_SPAN;
				return res;
			end
			nd = (d > month_days(ny, nm)) ? month_days(ny, nm) : d;
		end else begin
			t = 0;
			for (k = BASE_YEAR; k < y; k++)
				t += year_days(k);
			for (k = 1; k < m; k++)
				t += month_days(y, k);
			t += d - 1;
			t += (r.op == OP_WEEKS) ? amt * 7 : amt;
			ny = BASE_YEAR;
			while (ny < LIMIT_YEAR && t >= year_days(ny)) begin
				t -= year_days(ny);
				ny++;
			end
			if (ny >= LIMIT_YEAR) begin
				res.status = STAT_SPAN;
				return res;
			end
			nm = 1;
			while (nm < 12 && t >= month_days(ny, nm)) begin
				t -= month_days(ny, nm);
				nm++;
			end
			nd = t + 1;
		end
		res.day = DAY_W'(nd);
		res.month = MON_W'(nm);
		res.year = YEAR_W'(ny);
		res.status = STAT_OK;
		return res;
	endfunction

	function automatic void add_case(input logic [OP_W-1:0] o, input logic [DAY_W-1:0] d,
		input logic [MON_W-1:0] m, input logic [YEAR_W-1:0] y, input logic [AMT_W-1:0] a,
		input bit typed, input logic [DAY_W-1:0] ed, input logic [MON_W-1:0] em,
		input logic [YEAR_W-1:0] ey, input logic [STAT_W-1:0] es);
		date_case_t c;
		c.req = '{o, d, m, y, a};
		c.typed = typed;
		c.want = '{ed, em, ey, es};
		directed_cases.push_back(c);
	endfunction

	function automatic date_req_t make_random_request();
		date_req_t r;
		int kind, cap, left;
		r.op = OP_W'($urandom_range(3));
		r.amount = AMT_W'($urandom);
		kind = $urandom_range(99);
		if (kind < 10) begin
			r.day = DAY_W'($urandom);
			r.month = MON_W'($urandom);
			r.year = YEAR_W'($urandom);
		end else if (kind < 18) begin
			r.year = YEAR_W'(BASE_YEAR + $urandom_range(YEAR_SPAN - 1));
			r.month = MON_W'($urandom_range(12, 1));
			r.day = DAY_W'($urandom_range(28, 1));
			case ($urandom_range(3))
				0: r.day = '0;
				1: r.day = DAY_W'($urandom_range(31, month_days(r.year, r.month) + 1));
				2: r.year = YEAR_W'(BASE_YEAR - 1 - $urandom_range(3));
				default: r.year = YEAR_W'(LIMIT_YEAR + $urandom_range(3));
			endcase
		end else begin
			r.year = YEAR_W'(BASE_YEAR + $urandom_range(YEAR_SPAN - 1));
			r.month = MON_W'($urandom_range(12, 1));
			if ($urandom_range(3) == 0)
				r.day = DAY_W'(month_days(r.year, r.month));
			else
				r.day = DAY_W'($urandom_range(month_days(r.year, r.month), 1));
			left = LIMIT_YEAR - r.year;
			case (r.op)
				OP_DAYS:   cap = left * 366;
				OP_WEEKS:  cap = left * 53;
				OP_MONTHS: cap = left * 12;
				default:   cap = left;
			endcase
			if (cap > 65535)
				cap = 65535;
			case ($urandom_range(9))
				0:       r.amount = '0;
				1, 2:    r.amount = AMT_W'($urandom_range(40));
				3:       r.amount = AMT_W'($urandom);
				default: r.amount = AMT_W'($urandom_range(cap));
			endcase
		end
		return r;
	endfunction

	task automatic send_date_request(input date_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		op <= r.op;
		from_day <= r.day;
		from_month <= r.month;
		from_year <= r.year;
		amount <= r.amount;
		do
			@(posedge clk);
		while (full !== 1'b0);
	endtask

	task automatic check_date_result();
		date_result_t got, want;
		got = '{result_day, result_month, result_year, status};
		if (pending_dates.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected item: day %0d month %0d year %0d status %0d",
					got.day, got.month, got.year, got.status);
		end else begin
			want = pending_dates.pop_front();
			if (got.day !== want.day || got.month !== want.month ||
				got.year !== want.year || got.status !== want.status) begin
				fail_count++;
				if (fail_count <= 10)
					$display("mismatch: expected %0d-%0d-%0d st %0d, got %0d-%0d-%0d st %0d",
						want.year, want.month, want.day, want.status,
						got.year, got.month, got.day, got.status);
			end
		end
	endtask

	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop === 1'b1 && empty === 1'b0)
				check_date_result();
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		date_req_t req;
		arst_n = 1'b0;
		push = 1'b0;
		op = OP_DAYS;
		from_day = '0;
		from_month = '0;
		from_year = '0;
		amount = '0;

		add_case(OP_DAYS, 1, 1, 2000, 0, 1, 1, 1, 2000, STAT_OK);
		add_case(OP_WEEKS, 31, 12, 2127, 0, 1, 31, 12, 2127, STAT_OK);
		add_case(OP_DAYS, 1, 1, 2000, 16'hFFFF, 1, 0, 0, 0, STAT_SPAN);
		add_case(OP_WEEKS, 1, 1, 2000, 16'hFFFF, 1, 0, 0, 0, STAT_SPAN);
		add_case(OP_MONTHS, 1, 1, 2000, 16'hFFFF, 1, 0, 0, 0, STAT_SPAN);
		add_case(OP_YEARS, 1, 1, 2000, 16'hFFFF, 1, 0, 0, 0, STAT_SPAN);
		add_case(OP_DAYS, 0, 6, 2010, 5, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_DAYS, 10, 0, 2010, 5, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_MONTHS, 10, 13, 2010, 5, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_YEARS, 31, 15, 4095, 16'hFFFF, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_DAYS, 1, 1, 1999, 1, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_DAYS, 1, 1, 2128, 0, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_WEEKS, 31, 4, 2020, 1, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_DAYS, 29, 2, 2001, 1, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_DAYS, 29, 2, 2100, 0, 1, 0, 0, 0, STAT_BAD_DATE);
		add_case(OP_DAYS, 29, 2, 2000, 1, 1, 1, 3, 2000, STAT_OK);
		add_case(OP_DAYS, 31, 12, 2000, 1, 1, 1, 1, 2001, STAT_OK);
		add_case(OP_DAYS, 28, 2, 2100, 1, 1, 1, 3, 2100, STAT_OK);
		add_case(OP_MONTHS, 31, 1, 2001, 1, 1, 28, 2, 2001, STAT_OK);
		add_case(OP_MONTHS, 31, 1, 2004, 1, 1, 29, 2, 2004, STAT_OK);
		add_case(OP_YEARS, 29, 2, 2004, 1, 1, 28, 2, 2005, STAT_OK);
		add_case(OP_DAYS, 31, 12, 2127, 1, 1, 0, 0, 0, STAT_SPAN);
		add_case(OP_MONTHS, 1, 1, 2127, 12, 1, 0, 0, 0, STAT_SPAN);
		add_case(OP_YEARS, 15, 6, 2000, 127, 1, 15, 6, 2127, STAT_OK);
		add_case(OP_WEEKS, 15, 6, 2050, 1000, 0, 0, 0, 0, STAT_OK);
		add_case(OP_DAYS, 17, 9, 2033, 12345, 0, 0, 0, 0, STAT_OK);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[i]) begin
			send_date_request(directed_cases[i].req);
			if (directed_cases[i].typed)
				pending_dates.push_back(directed_cases[i].want);
			else
				pending_dates.push_back(predict_date_sum(directed_cases[i].req));
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (567) begin
				req = make_random_request();
				send_date_request(req);
				pending_dates.push_back(predict_date_sum(req));
			end
		end
		push <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (YEAR_SPAN + 40) @(posedge clk);

		if (fail_count == 0)
			$display("** calendar_date_add_core: PASSED **");
		else
			$display("** calendar_date_add_core: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/cda_pkg.sv
hdl/cda_front.sv
hdl/cda_queue.sv
hdl/cda_back.sv
hdl/calendar_date_add_core.sv
sim/calendar_date_add_core_test.sv
